### src/lemt_pkg.sv
// Shared types and constants for the endpoint mask table.
// Used by lemt_mem, lemt_ctrl and link_endpoint_mask_table; no dependencies.
package lemt_pkg;

   localparam int ENTRIES_DEFAULT = 8;
   localparam int ADDR_W          = 48;
   localparam int MASK_W          = 8;
   localparam int OPC_W           = 2;
   localparam int STAT_W          = 2;

   typedef enum logic [OPC_W-1:0] {
      OP_CONNECT    = 2'd0,
      OP_DISCONNECT = 2'd1,
      OP_REMOVE     = 2'd2,
      OP_QUERY      = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC
   } state_type;

   // One stored entry: key and endpoint-type mask.
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [MASK_W-1:0] mask;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic              found;
      status_type        status;
      logic [MASK_W-1:0] mask;
   } rsp_type;

endpackage

### src/lemt_mem.sv
// Entry memory: one write port, one read port with registered read data.
// Depends on lemt_pkg for the entry type.
module lemt_mem #(
   parameter int  ENTRIES = lemt_pkg::ENTRIES_DEFAULT,
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  lemt_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_idx,
   output lemt_pkg::entry_type rd_data
);
   import lemt_pkg::*;

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/lemt_ctrl.sv
// Sequencer: scans the entry memory one entry a cycle, keeps the valid bits,
// then applies the item with at most one write back. Depends on lemt_pkg.
module lemt_ctrl #(
   parameter int  ENTRIES = lemt_pkg::ENTRIES_DEFAULT,
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lemt_pkg::OPC_W-1:0]    req_opcode,
   input  logic [lemt_pkg::ADDR_W-1:0]   req_device_address,
   input  logic [lemt_pkg::MASK_W-1:0]   req_type_mask,
   output logic                          rd_en,
   output logic [IDX_W-1:0]              rd_idx,
   input  lemt_pkg::entry_type           rd_data,
   output logic                          wr_en,
   output logic [IDX_W-1:0]              wr_idx,
   output lemt_pkg::entry_type           wr_data,
   output lemt_pkg::rsp_type             rsp
);
   import lemt_pkg::*;

   localparam int CNT_W = $clog2(ENTRIES + 1);

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [MASK_W-1:0] tmask_ff, tmask_in;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              cmp_pend_ff, cmp_pend_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [MASK_W-1:0] hit_mask_ff, hit_mask_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic              hit_now;
   logic              last_cmp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         cmp_pend_ff   <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rd_cnt_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         cmp_pend_ff   <= cmp_pend_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         rd_cnt_ff     <= rd_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      tmask_ff    <= tmask_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_mask_ff <= hit_mask_in;
      free_idx_ff <= free_idx_in;
   end

   assign hit_now  = cmp_pend_ff && valid_ff[cmp_idx_ff] && (rd_data.addr == addr_ff);
   assign last_cmp = (cmp_idx_ff == IDX_W'(ENTRIES - 1));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      tmask_in      = tmask_ff;
      rd_cnt_in     = rd_cnt_ff;
      cmp_pend_in   = cmp_pend_ff;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_mask_in   = hit_mask_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      busy          = (state_ff != ST_IDLE);
      rd_en         = 1'b0;
      rd_idx        = rd_cnt_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_idx        = hit_ff ? hit_idx_ff : free_idx_ff;
      wr_data       = '{addr: addr_ff, mask: '0};
      rsp           = '{valid: 1'b0, found: 1'b0, status: STATUS_OK, mask: '0};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in         = op_type'(req_opcode);
               addr_in       = req_device_address;
               tmask_in      = req_type_mask;
               rd_cnt_in     = '0;
               cmp_pend_in   = 1'b0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue the next read while comparing the previous one
            if (rd_cnt_ff < CNT_W'(ENTRIES)) begin
               rd_en     = 1'b1;
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            cmp_pend_in = rd_en;
            cmp_idx_in  = rd_idx;
            if (cmp_pend_ff) begin
               if (hit_now) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = cmp_idx_ff;
                  hit_mask_in = rd_data.mask;
                  cmp_pend_in = 1'b0;
                  state_in    = ST_EXEC;
               end else begin
                  // remember the lowest free slot for a possible allocation
                  if (!valid_ff[cmp_idx_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = cmp_idx_ff;
                  end
                  if (last_cmp) begin
                     cmp_pend_in = 1'b0;
                     state_in    = ST_EXEC;
                  end
               end
            end
         end
         ST_EXEC: begin
            rsp.valid = 1'b1;
            rsp.found = hit_ff;
            unique case (op_ff)
               OP_CONNECT: begin
                  priority if (hit_ff) begin
                     wr_en        = 1'b1;
                     wr_data.mask = hit_mask_ff | tmask_ff;
                     rsp.mask     = hit_mask_ff | tmask_ff;
                  end else if (free_found_ff) begin
                     // new entry starts empty, so its mask is the item's mask
                     wr_en                 = 1'b1;
                     wr_data.mask          = tmask_ff;
                     rsp.mask              = tmask_ff;
                     valid_in[free_idx_ff] = 1'b1;
                  end else begin
                     rsp.status = STATUS_FULL;
                  end
               end
               OP_DISCONNECT: begin
                  if (hit_ff) begin
                     wr_en        = 1'b1;
                     wr_data.mask = hit_mask_ff & ~tmask_ff;
                     rsp.mask     = hit_mask_ff & ~tmask_ff;
                  end else begin
                     rsp.status = STATUS_NOT_FOUND;
                  end
               end
               OP_REMOVE: begin
                  if (hit_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                  end
               end
               OP_QUERY: begin
                  if (hit_ff) begin
                     rsp.mask = hit_mask_ff;
                  end
               end
               default: begin
                  rsp.status = STATUS_OK;
               end
            endcase
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### src/link_endpoint_mask_table.sv
// Endpoint mask table, top level. An item scans the entries in order from index 0 until
// one matches or the last is compared, and its result is then registered onto rsp_valid;
// the scan reads the entry memory through its single read port, one entry a cycle.
// busy is low again in the strobe cycle, so a new item may start there.
// Synchronous reset clears all valid bits at once; no clearing pass is needed.
// The receiver cannot stall: rsp_valid is high for one cycle only, the fields hold after.
module link_endpoint_mask_table #(
   parameter int ENTRIES = lemt_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lemt_pkg::OPC_W-1:0]    req_opcode,
   input  logic [lemt_pkg::ADDR_W-1:0]   req_device_address,
   input  logic [lemt_pkg::MASK_W-1:0]   req_type_mask,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [lemt_pkg::STAT_W-1:0]   rsp_status,
   output logic [lemt_pkg::MASK_W-1:0]   rsp_stored_mask
);
   import lemt_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic             rd_en;
   logic [IDX_W-1:0] rd_idx;
   entry_type        rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_data;
   rsp_type          rsp;

   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   status_type        rsp_status_ff;
   logic [MASK_W-1:0] rsp_mask_ff;

   lemt_mem #(.ENTRIES(ENTRIES)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   lemt_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_device_address (req_device_address),
      .req_type_mask      (req_type_mask),
      .rd_en              (rd_en),
      .rd_idx             (rd_idx),
      .rd_data            (rd_data),
      .wr_en              (wr_en),
      .wr_idx             (wr_idx),
      .wr_data            (wr_data),
      .rsp                (rsp)
   );

   // register the result so the strobe and fields come straight from flops
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp.valid) begin
         rsp_found_ff  <= rsp.found;
         rsp_status_ff <= rsp.status;
         rsp_mask_ff   <= rsp.mask;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_stored_mask = rsp_mask_ff;

endmodule
